@@ src/misty1_pkg.sv @@
// misty1_pkg: shared types, register indexes and s-box tables of the misty1 cipher
// no dependencies; imported by misty1_block_cipher_top and tb
package misty1_pkg;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_KEYS = 5'b00010,
    ST_FL   = 5'b00100,
    ST_FO   = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_KEY_HIGH    = 2'd0;
  localparam cfg_index_t CFG_KEY_LOW     = 2'd1;
  localparam cfg_index_t CFG_ROUND_COUNT = 2'd2;

  localparam logic [5:0] ROUND_COUNT_RESET = 6'd8;

  localparam logic [6:0] S7_TAB [128] = '{
    7'h1b,7'h32,7'h33,7'h5a,7'h3b,7'h10,7'h17,7'h54,7'h5b,7'h1a,7'h72,7'h73,7'h6b,7'h2c,7'h66,7'h49,
    7'h1f,7'h24,7'h13,7'h6c,7'h37,7'h2e,7'h3f,7'h4a,7'h5d,7'h0f,7'h40,7'h56,7'h25,7'h51,7'h1c,7'h04,
    7'h0b,7'h46,7'h20,7'h0d,7'h7b,7'h35,7'h44,7'h42,7'h2b,7'h1e,7'h41,7'h14,7'h4b,7'h79,7'h15,7'h6f,
    7'h0e,7'h55,7'h09,7'h36,7'h74,7'h0c,7'h67,7'h53,7'h28,7'h0a,7'h7e,7'h38,7'h02,7'h07,7'h60,7'h29,
    7'h19,7'h12,7'h65,7'h2f,7'h30,7'h39,7'h08,7'h68,7'h5f,7'h78,7'h2a,7'h4c,7'h64,7'h45,7'h75,7'h3d,
    7'h59,7'h48,7'h03,7'h57,7'h7c,7'h4f,7'h62,7'h3c,7'h1d,7'h21,7'h5e,7'h27,7'h6a,7'h70,7'h4d,7'h3a,
    7'h01,7'h6d,7'h6e,7'h63,7'h18,7'h77,7'h23,7'h05,7'h26,7'h76,7'h00,7'h31,7'h2d,7'h7a,7'h7f,7'h61,
    7'h50,7'h22,7'h11,7'h06,7'h47,7'h16,7'h52,7'h4e,7'h71,7'h3e,7'h69,7'h43,7'h34,7'h5c,7'h58,7'h7d
  };

  localparam logic [8:0] S9_TAB [512] = '{
    9'h1c3,9'h0cb,9'h153,9'h19f,9'h1e3,9'h0e9,9'h0fb,9'h035,
    9'h181,9'h0b9,9'h117,9'h1eb,9'h133,9'h009,9'h02d,9'h0d3,
    9'h0c7,9'h14a,9'h037,9'h07e,9'h0eb,9'h164,9'h193,9'h1d8,
    9'h0a3,9'h11e,9'h055,9'h02c,9'h01d,9'h1a2,9'h163,9'h118,
    9'h14b,9'h152,9'h1d2,9'h00f,9'h02b,9'h030,9'h13a,9'h0e5,
    9'h111,9'h138,9'h18e,9'h063,9'h0e3,9'h0c8,9'h1f4,9'h01b,
    9'h001,9'h09d,9'h0f8,9'h1a0,9'h16d,9'h1f3,9'h01c,9'h146,
    9'h07d,9'h0d1,9'h082,9'h1ea,9'h183,9'h12d,9'h0f4,9'h19e,
    9'h1d3,9'h0dd,9'h1e2,9'h128,9'h1e0,9'h0ec,9'h059,9'h091,
    9'h011,9'h12f,9'h026,9'h0dc,9'h0b0,9'h18c,9'h10f,9'h1f7,
    9'h0e7,9'h16c,9'h0b6,9'h0f9,9'h0d8,9'h151,9'h101,9'h14c,
    9'h103,9'h0b8,9'h154,9'h12b,9'h1ae,9'h017,9'h071,9'h00c,
    9'h047,9'h058,9'h07f,9'h1a4,9'h134,9'h129,9'h084,9'h15d,
    9'h19d,9'h1b2,9'h1a3,9'h048,9'h07c,9'h051,9'h1ca,9'h023,
    9'h13d,9'h1a7,9'h165,9'h03b,9'h042,9'h0da,9'h192,9'h0ce,
    9'h0c1,9'h06b,9'h09f,9'h1f1,9'h12c,9'h184,9'h0fa,9'h196,
    9'h1e1,9'h169,9'h17d,9'h031,9'h180,9'h10a,9'h094,9'h1da,
    9'h186,9'h13e,9'h11c,9'h060,9'h175,9'h1cf,9'h067,9'h119,
    9'h065,9'h068,9'h099,9'h150,9'h008,9'h007,9'h17c,9'h0b7,
    9'h024,9'h019,9'h0de,9'h127,9'h0db,9'h0e4,9'h1a9,9'h052,
    9'h109,9'h090,9'h19c,9'h1c1,9'h028,9'h1b3,9'h135,9'h16a,
    9'h176,9'h0df,9'h1e5,9'h188,9'h0c5,9'h16e,9'h1de,9'h1b1,
    9'h0c3,9'h1df,9'h036,9'h0ee,9'h1ee,9'h0f0,9'h093,9'h049,
    9'h09a,9'h1b6,9'h069,9'h081,9'h125,9'h00b,9'h05e,9'h0b4,
    9'h149,9'h1c7,9'h174,9'h03e,9'h13b,9'h1b7,9'h08e,9'h1c6,
    9'h0ae,9'h010,9'h095,9'h1ef,9'h04e,9'h0f2,9'h1fd,9'h085,
    9'h0fd,9'h0f6,9'h0a0,9'h16f,9'h083,9'h08a,9'h156,9'h09b,
    9'h13c,9'h107,9'h167,9'h098,9'h1d0,9'h1e9,9'h003,9'h1fe,
    9'h0bd,9'h122,9'h089,9'h0d2,9'h18f,9'h012,9'h033,9'h06a,
    9'h142,9'h0ed,9'h170,9'h11b,9'h0e2,9'h14f,9'h158,9'h131,
    9'h147,9'h05d,9'h113,9'h1cd,9'h079,9'h161,9'h1a5,9'h179,
    9'h09e,9'h1b4,9'h0cc,9'h022,9'h132,9'h01a,9'h0e8,9'h004,
    9'h187,9'h1ed,9'h197,9'h039,9'h1bf,9'h1d7,9'h027,9'h18b,
    9'h0c6,9'h09c,9'h0d0,9'h14e,9'h06c,9'h034,9'h1f2,9'h06e,
    9'h0ca,9'h025,9'h0ba,9'h191,9'h0fe,9'h013,9'h106,9'h02f,
    9'h1ad,9'h172,9'h1db,9'h0c0,9'h10b,9'h1d6,9'h0f5,9'h1ec,
    9'h10d,9'h076,9'h114,9'h1ab,9'h075,9'h10c,9'h1e4,9'h159,
    9'h054,9'h11f,9'h04b,9'h0c4,9'h1be,9'h0f7,9'h029,9'h0a4,
    9'h00e,9'h1f0,9'h077,9'h04d,9'h17a,9'h086,9'h08b,9'h0b3,
    9'h171,9'h0bf,9'h10e,9'h104,9'h097,9'h15b,9'h160,9'h168,
    9'h0d7,9'h0bb,9'h066,9'h1ce,9'h0fc,9'h092,9'h1c5,9'h06f,
    9'h016,9'h04a,9'h0a1,9'h139,9'h0af,9'h0f1,9'h190,9'h00a,
    9'h1aa,9'h143,9'h17b,9'h056,9'h18d,9'h166,9'h0d4,9'h1fb,
    9'h14d,9'h194,9'h19a,9'h087,9'h1f8,9'h123,9'h0a7,9'h1b8,
    9'h141,9'h03c,9'h1f9,9'h140,9'h02a,9'h155,9'h11a,9'h1a1,
    9'h198,9'h0d5,9'h126,9'h1af,9'h061,9'h12e,9'h157,9'h1dc,
    9'h072,9'h18a,9'h0aa,9'h096,9'h115,9'h0ef,9'h045,9'h07b,
    9'h08d,9'h145,9'h053,9'h05f,9'h178,9'h0b2,9'h02e,9'h020,
    9'h1d5,9'h03f,9'h1c9,9'h1e7,9'h1ac,9'h044,9'h038,9'h014,
    9'h0b1,9'h16b,9'h0ab,9'h0b5,9'h05a,9'h182,9'h1c8,9'h1d4,
    9'h018,9'h177,9'h064,9'h0cf,9'h06d,9'h100,9'h199,9'h130,
    9'h15a,9'h005,9'h120,9'h1bb,9'h1bd,9'h0e0,9'h04f,9'h0d6,
    9'h13f,9'h1c4,9'h12a,9'h015,9'h006,9'h0ff,9'h19b,9'h0a6,
    9'h043,9'h088,9'h050,9'h15f,9'h1e8,9'h121,9'h073,9'h17e,
    9'h0bc,9'h0c2,9'h0c9,9'h173,9'h189,9'h1f5,9'h074,9'h1cc,
    9'h1e6,9'h1a8,9'h195,9'h01f,9'h041,9'h00d,9'h1ba,9'h032,
    9'h03d,9'h1d1,9'h080,9'h0a8,9'h057,9'h1b9,9'h162,9'h148,
    9'h0d9,9'h105,9'h062,9'h07a,9'h021,9'h1ff,9'h112,9'h108,
    9'h1c0,9'h0a9,9'h11d,9'h1b0,9'h1a6,9'h0cd,9'h0f3,9'h05c,
    9'h102,9'h05b,9'h1d9,9'h144,9'h1f6,9'h0ad,9'h0a5,9'h03a,
    9'h1cb,9'h136,9'h17f,9'h046,9'h0e1,9'h01e,9'h1dd,9'h0e6,
    9'h137,9'h1fa,9'h185,9'h08c,9'h08f,9'h040,9'h1b5,9'h0be,
    9'h078,9'h000,9'h0ac,9'h110,9'h15e,9'h124,9'h002,9'h1bc,
    9'h0a2,9'h0ea,9'h070,9'h1fc,9'h116,9'h15c,9'h04c,9'h1c2
  };

endpackage

@@ src/misty1_block_cipher_top.sv @@
// misty1_block_cipher_top: misty1 64-bit block cipher, 128-bit key, with key schedule
// depends on misty1_pkg (state type, register indexes, s7 and s9 tables)
//
// usage
//   input channel: action (0 encrypt, 1 decrypt) and block_in, one transfer per block
//   when in_valid is high and in_stall is low. output channel: block_out, one transfer
//   per block when out_valid is high and out_stall is low.
//   config channel: cfg_index selects key_high, key_low or round_count, cfg_data is the
//   value; a write completes when cfg_valid and cfg_ready are both high. a key write
//   rebuilds the eight derived subkeys with 8 fi passes, one per subkey.
// operation
//   each fi function runs as an s9 lookup, an s7 lookup with key mix and a second s9
//   lookup, in that order; an fo function is three fi passes, and an fl layer pair is
//   applied at once in the fl state. one block is worked on at a time.
// reset
//   rst clears the key to zero, sets round_count to 8 and runs the key schedule for the
//   zero key before the first block is taken.
// stall
//   a finished block waits in the output register; the next block may be taken
//   meanwhile and only its final hand-over waits until the output register is free.
module misty1_block_cipher_top #(
  parameter int MAX_ROUNDS = 36
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [63:0]            block_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            block_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  misty1_pkg::cfg_index_t cfg_index,
  input  logic [63:0]            cfg_data
);
  import misty1_pkg::*;

  // rounds and layer index (n + 1) must fit
  localparam int RW = $clog2(MAX_ROUNDS + 2);
  localparam logic [6:0] MAX_R7 = 7'(MAX_ROUNDS);
  localparam logic [RW-1:0] ONE_R = RW'(1);

  // key halves k0..k7 and derived words kp0..kp7, word 0 in the top bits
  logic [127:0] key;
  logic [127:0] kp;
  logic [5:0]   round_count;

  state_t       state;
  logic [1:0]   ph;         // fi phase
  logic [1:0]   fo_j;       // which fi inside fo
  logic [2:0]   ks_i;       // key schedule word
  logic [RW-1:0] r;         // round counter
  logic [RW-1:0] layer;     // fl layer index
  logic          dec;
  logic          first_fl;

  logic [31:0]  d0;
  logic [31:0]  d1;
  logic [15:0]  t0;
  logic [15:0]  t1;
  logic [8:0]   fi_d9;
  logic [6:0]   fi_d7;

  logic [RW-1:0] n_rounds;
  logic [15:0]   fi_in;
  logic [15:0]   fi_key;
  logic [15:0]   fi_out;
  logic [8:0]    fi_lo;
  logic [2:0]    k;
  logic [31:0]   fo_src;
  logic [31:0]   fo_res;
  logic [31:0]   fl_d0;
  logic [31:0]   fl_d1;
  logic          in_xfer;
  logic          cfg_xfer;
  logic          out_free;

  function automatic logic [15:0] word(input logic [127:0] v, input logic [2:0] i);
    word = v[{(3'd7 - i), 4'hf} -: 16];
  endfunction

  // fl sublayer: forward or inverse, layer index mod 16 picks the keys
  function automatic logic [31:0] fl_apply(input logic [31:0] x, input logic [3:0] l,
                                           input logic inv, input logic [127:0] kk,
                                           input logic [127:0] kw);
    logic [15:0] ka;
    logic [15:0] ko;
    logic [15:0] a;
    logic [15:0] b;
    logic [2:0]  j;
    j = l[3:1];
    if (l[0]) begin
      ka = word(kw, j + 3'd2);
      ko = word(kk, j + 3'd4);
    end else begin
      ka = word(kk, j);
      ko = word(kw, j + 3'd6);
    end
    a = x[31:16];
    b = x[15:0];
    if (inv) begin
      a = a ^ (b | ko);
      b = b ^ (a & ka);
    end else begin
      b = b ^ (a & ka);
      a = a ^ (b | ko);
    end
    fl_apply = {a, b};
  endfunction

  always_comb begin
    if (round_count == 6'd0) begin
      n_rounds = ONE_R;
    end else if ({1'b0, round_count} > MAX_R7) begin
      n_rounds = RW'(MAX_ROUNDS);
    end else begin
      n_rounds = RW'(round_count);
    end
  end

  assign k      = r[2:0];
  assign fo_src = r[0] ? d1 : d0;

  // fi operands, each needed in a single phase only
  always_comb begin
    fi_in  = 16'h0000;
    fi_key = 16'h0000;
    if (state == ST_KEYS) begin
      fi_in  = word(key, ks_i);
      fi_key = word(key, ks_i + 3'd1);
    end else begin
      case (fo_j)
        2'd0: begin
          fi_in  = fo_src[31:16] ^ word(key, k);
          fi_key = word(kp, k + 3'd5);
        end
        2'd1: begin
          fi_in  = t1 ^ word(key, k + 3'd2);
          fi_key = word(kp, k + 3'd1);
        end
        2'd2: begin
          fi_in  = t0 ^ word(key, k + 3'd7);
          fi_key = word(kp, k + 3'd3);
        end
        default: begin
          fi_in  = 16'h0000;
          fi_key = 16'h0000;
        end
      endcase
    end
  end

  assign fi_lo  = S9_TAB[fi_d9] ^ {2'b00, fi_d7};
  assign fi_out = {fi_d7, fi_lo};
  assign fo_res = {t1 ^ word(key, k + 3'd4), fi_out ^ t1};

  assign fl_d0 = fl_apply(d0, layer[3:0], dec, key, kp);
  assign fl_d1 = fl_apply(d1, layer[3:0] + 4'd1, dec, key, kp);

  // a register write offered in idle takes priority, so the input holds off
  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  // fi datapath registers, shared by key schedule and fo
  always_ff @(posedge clk) begin
    case (ph)
      2'd0: begin
        fi_d9 <= S9_TAB[fi_in[15:7]] ^ {2'b00, fi_in[6:0]};
        fi_d7 <= fi_in[6:0];
      end
      2'd1: begin
        fi_d7 <= S7_TAB[fi_d7] ^ fi_d9[6:0] ^ fi_key[15:9];
        fi_d9 <= fi_d9 ^ fi_key[8:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_KEYS;
      key         <= 128'd0;
      round_count <= ROUND_COUNT_RESET;
      ph          <= 2'd0;
      fo_j        <= 2'd0;
      ks_i        <= 3'd0;
      r           <= '0;
      layer       <= '0;
      dec         <= 1'b0;
      first_fl    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_xfer) begin
            // a key write restarts the schedule, round count needs none
            case (cfg_index)
              CFG_KEY_HIGH: begin
                key[127:64] <= cfg_data;
                state       <= ST_KEYS;
                ks_i        <= 3'd0;
                ph          <= 2'd0;
              end
              CFG_KEY_LOW: begin
                key[63:0] <= cfg_data;
                state     <= ST_KEYS;
                ks_i      <= 3'd0;
                ph        <= 2'd0;
              end
              CFG_ROUND_COUNT: begin
                round_count <= cfg_data[5:0];
              end
              default: begin
              end
            endcase
          end else if (in_xfer) begin
            dec      <= action;
            first_fl <= 1'b1;
            state    <= ST_FL;
            fo_j     <= 2'd0;
            ph       <= 2'd0;
            if (action) begin
              d1    <= block_in[63:32];
              d0    <= block_in[31:0];
              layer <= n_rounds;
              r     <= n_rounds - ONE_R;
            end else begin
              d0    <= block_in[63:32];
              d1    <= block_in[31:0];
              layer <= '0;
              r     <= '0;
            end
          end
        end
        ST_KEYS: begin
          if (ph == 2'd2) begin
            ph <= 2'd0;
            kp[{(3'd7 - ks_i), 4'hf} -: 16] <= fi_out;
            ks_i <= ks_i + 3'd1;
            if (ks_i == 3'd7) begin
              state <= ST_IDLE;
            end
          end else begin
            ph <= ph + 2'd1;
          end
        end
        ST_FL: begin
          d0       <= fl_d0;
          d1       <= fl_d1;
          first_fl <= 1'b0;
          if (!dec) begin
            state <= (r == n_rounds) ? ST_DONE : ST_FO;
          end else if (first_fl) begin
            state <= ST_FO;
          end else if (r == '0) begin
            state <= ST_DONE;
          end else begin
            r     <= r - ONE_R;
            state <= ST_FO;
          end
        end
        ST_FO: begin
          if (ph == 2'd2) begin
            ph <= 2'd0;
            case (fo_j)
              2'd0: begin
                t0   <= fi_out ^ fo_src[15:0];
                t1   <= fo_src[15:0];
                fo_j <= 2'd1;
              end
              2'd1: begin
                t1   <= fi_out ^ t0;
                fo_j <= 2'd2;
              end
              default: begin
                fo_j <= 2'd0;
                // odd rounds feed d0, even rounds d1
                if (r[0]) begin
                  d0 <= d0 ^ fo_res;
                end else begin
                  d1 <= d1 ^ fo_res;
                end
                if (!dec) begin
                  r <= r + ONE_R;
                  if ((r + ONE_R) == n_rounds) begin
                    layer <= n_rounds;
                    state <= ST_FL;
                  end else if (!r[0]) begin
                    state <= ST_FO;
                  end else begin
                    layer <= r + ONE_R;
                    state <= ST_FL;
                  end
                end else if (!r[0]) begin
                  layer <= r;
                  state <= ST_FL;
                end else begin
                  r <= r - ONE_R;
                end
              end
            endcase
          end else begin
            ph <= ph + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            block_out <= dec ? {d0, d1} : {d1, d0};
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a transfer always starts with an fl layer pair
  a_start_fl: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_FL)
    else $error("block taken without starting at an fl layer");

  // fo only ever runs on a round below the active count
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FO |-> r < n_rounds)
    else $error("round counter out of range during fo");

  // a key write always reruns the key schedule
  a_key_sched: assert property (@(posedge clk) disable iff (rst)
    cfg_xfer && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)
    |=> state == ST_KEYS && ks_i == 3'd0 && ph == 2'd0)
    else $error("key write did not restart the schedule");

  // a result is loaded only when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && out_stall |=> out_valid && $stable(block_out))
    else $error("pending result overwritten");

  // fi phase counter stays within its three steps
  a_fi_phase: assert property (@(posedge clk) disable iff (rst)
    ph != 2'd3)
    else $error("fi phase out of range");

endmodule

@@ sim/tb.sv @@
// tb: self-checking testbench for misty1_block_cipher_top, encrypt and decrypt under many keys
// depends on misty1_pkg (register indexes, s7 and s9 tables) and the block under test
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import misty1_pkg::*;

  // index past the end of the register list, must be ignored
  localparam cfg_index_t CFG_UNUSED = 2'd3;
  localparam int ROUND_LIMIT = 36;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ACT_ENCRYPT = 0;
  localparam int ACT_DECRYPT = 1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [63:0] block_in;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] block_out;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [63:0] cfg_data;

  misty1_block_cipher_top #(.MAX_ROUNDS(ROUND_LIMIT)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .block_in(block_in),
    .out_valid(out_valid), .out_stall(out_stall), .block_out(block_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the register file and key schedule
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [5:0]  rounds_q;
  logic [15:0] subkey [16];

  logic [63:0] pending_blocks [$];
  int          n_errors;
  int          n_blocks_sent;
  int          n_blocks_checked;
  int          n_cfg_writes;
  bit          sender_gaps;
  bit          receiver_gaps;
  int          hold_left;
  int          stall_left;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] fi_fn(input logic [15:0] x, input logic [15:0] k);
    logic [8:0] d9;
    logic [6:0] d7;
    d9 = x[15:7];
    d7 = x[6:0];
    d9 = S9_TAB[d9] ^ {2'b00, d7};
    d7 = S7_TAB[d7] ^ d9[6:0];
    d7 = d7 ^ k[15:9];
    d9 = d9 ^ k[8:0];
    d9 = S9_TAB[d9] ^ {2'b00, d7};
    return {d7, d9};
  endfunction

  function automatic logic [31:0] fo_fn(input logic [31:0] x, input int r);
    logic [15:0] t0;
    logic [15:0] t1;
    int k;
    k = r & 7;
    t0 = x[31:16];
    t1 = x[15:0];
    t0 = fi_fn(t0 ^ subkey[k], subkey[((k + 5) & 7) + 8]) ^ t1;
    t1 = fi_fn(t1 ^ subkey[(k + 2) & 7], subkey[((k + 1) & 7) + 8]) ^ t0;
    t0 = fi_fn(t0 ^ subkey[(k + 7) & 7], subkey[((k + 3) & 7) + 8]) ^ t1;
    t1 = t1 ^ subkey[(k + 4) & 7];
    return {t1, t0};
  endfunction

  // and-key and or-key of fl layer r; indexes wrap so the schedule repeats every 16 layers
  function automatic logic [31:0] fl_keys(input int r);
    int j;
    j = (r >> 1) & 7;
    if ((r & 1) == 0) begin
      return {subkey[j], subkey[((j + 6) & 7) + 8]};
    end
    return {subkey[((j + 2) & 7) + 8], subkey[(j + 4) & 7]};
  endfunction

  function automatic logic [31:0] fl_fn(input logic [31:0] x, input int r, input bit inv);
    logic [31:0] ks;
    logic [15:0] d0;
    logic [15:0] d1;
    ks = fl_keys(r);
    d0 = x[31:16];
    d1 = x[15:0];
    if (!inv) begin
      d1 = d1 ^ (d0 & ks[31:16]);
      d0 = d0 ^ (d1 | ks[15:0]);
    end else begin
      d0 = d0 ^ (d1 | ks[15:0]);
      d1 = d1 ^ (d0 & ks[31:16]);
    end
    return {d0, d1};
  endfunction

  task automatic rebuild_subkeys();
    for (int i = 0; i < 4; i++) begin
      subkey[i]     = key_hi_q[63 - 16 * i -: 16];
      subkey[i + 4] = key_lo_q[63 - 16 * i -: 16];
    end
    for (int i = 0; i < 8; i++) subkey[i + 8] = fi_fn(subkey[i], subkey[(i + 1) & 7]);
  endtask

  function automatic logic [63:0] cipher_result(input bit dec, input logic [63:0] blk);
    int n;
    logic [31:0] d0;
    logic [31:0] d1;
    // zero means one round, anything past the limit saturates
    n = (rounds_q == 0) ? 1 : ((rounds_q > ROUND_LIMIT) ? ROUND_LIMIT : rounds_q);
    if (!dec) begin
      d0 = blk[63:32];
      d1 = blk[31:0];
      for (int i = 0; i < n; i++) begin
        if ((i & 1) == 0) begin
          d0 = fl_fn(d0, i, 1'b0);
          d1 = fl_fn(d1, i + 1, 1'b0) ^ fo_fn(d0, i);
        end else begin
          d0 = d0 ^ fo_fn(d1, i);
        end
      end
      d0 = fl_fn(d0, n, 1'b0);
      d1 = fl_fn(d1, n + 1, 1'b0);
      return {d1, d0};
    end
    d1 = fl_fn(blk[63:32], n + 1, 1'b1);
    d0 = fl_fn(blk[31:0], n, 1'b1);
    for (int r = n - 1; r >= 0; r--) begin
      if ((r & 1) == 0) begin
        d1 = d1 ^ fo_fn(d0, r);
        d0 = fl_fn(d0, r, 1'b1);
        d1 = fl_fn(d1, r + 1, 1'b1);
      end else begin
        d0 = d0 ^ fo_fn(d1, r);
      end
    end
    return {d0, d1};
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // one block transfer; the expectation is queued on acceptance
  task automatic send_block(input bit dec, input logic [63:0] blk);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= dec;
    block_in <= blk;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_blocks.push_back(cipher_result(dec, blk));
    n_blocks_sent++;
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    sender_idle();
    wait_drained();
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_HIGH: begin
        key_hi_q = val;
        rebuild_subkeys();
      end
      CFG_KEY_LOW: begin
        key_lo_q = val;
        rebuild_subkeys();
      end
      CFG_ROUND_COUNT: rounds_q = val[5:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly short round counts so the run stays quick, now and then the full 36
  function automatic logic [5:0] pick_rounds();
    return ($urandom_range(0, 9) == 0) ? 6'd36 : 6'($urandom_range(1, 8));
  endfunction

  // result checker and stall generator of the output side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected result", block_out, '0);
      end else begin
        if (block_out !== pending_blocks[0])
          report_mismatch("block_out", block_out, pending_blocks[0]);
        void'(pending_blocks.pop_front());
      end
      n_blocks_checked++;
      stall_left = receiver_gaps ? $urandom_range(0, 9) : 0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results still outstanding", pending_blocks.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    logic [63:0] pats [3];
    pats[0] = 64'h0;
    pats[1] = 64'hffff_ffff_ffff_ffff;
    pats[2] = 64'h0123_4567_89ab_cdef;
    // zero key straight out of reset, standard 8 rounds
    foreach (pats[i]) begin
      send_block(ACT_ENCRYPT, pats[i]);
      send_block(ACT_DECRYPT, pats[i]);
    end
    // published key, then all-ones key
    write_reg(CFG_KEY_HIGH, 64'h0011_2233_4455_6677);
    write_reg(CFG_KEY_LOW, 64'h8899_aabb_ccdd_eeff);
    send_block(ACT_ENCRYPT, pats[2]);
    send_block(ACT_DECRYPT, 64'h8b1d_a5f5_6ab3_d07c);
    // write past the register list leaves everything alone
    write_reg(CFG_UNUSED, 64'hdead_beef_dead_beef);
    send_block(ACT_ENCRYPT, pats[2]);
    // round count extremes: zero, one, nine (schedule wraps), limit, above limit
    write_reg(CFG_ROUND_COUNT, 64'd0);
    send_block(ACT_ENCRYPT, pats[1]);
    send_block(ACT_DECRYPT, pats[1]);
    write_reg(CFG_ROUND_COUNT, 64'd1);
    send_block(ACT_ENCRYPT, pats[2]);
    write_reg(CFG_ROUND_COUNT, 64'd9);
    send_block(ACT_ENCRYPT, pats[2]);
    send_block(ACT_DECRYPT, pats[2]);
    write_reg(CFG_ROUND_COUNT, 64'd36);
    send_block(ACT_ENCRYPT, pats[2]);
    write_reg(CFG_ROUND_COUNT, 64'hffff_ffff_ffff_ffff);
    send_block(ACT_DECRYPT, pats[0]);
    write_reg(CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_ROUND_COUNT, 64'd8);
    send_block(ACT_ENCRYPT, pats[0]);
    send_block(ACT_DECRYPT, pats[1]);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_KEY_HIGH, rand64());
      write_reg(CFG_KEY_LOW, rand64());
      write_reg(CFG_ROUND_COUNT, 64'(pick_rounds()));
      repeat (85) send_block(1'($urandom_range(0, 1)), rand64());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input side stalls
  task automatic test_backpressure();
    write_reg(CFG_ROUND_COUNT, 64'd2);
    wait (out_stall == 1'b0);
    hold_left = 400;
    repeat (6) send_block(1'($urandom_range(0, 1)), rand64());
  endtask

  // sender pauses until every result is back, then carries on
  task automatic test_pause();
    write_reg(CFG_ROUND_COUNT, 64'(pick_rounds()));
    repeat (3) begin
      repeat (10) send_block(1'($urandom_range(0, 1)), rand64());
      sender_idle();
      wait_drained();
    end
  endtask

  // back to back on both sides
  task automatic test_no_idle();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    write_reg(CFG_ROUND_COUNT, 64'd1);
    repeat (40) send_block(1'($urandom_range(0, 1)), rand64());
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = 1'b0;
    block_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KEY_HIGH;
    cfg_data  = '0;
    n_errors = 0;
    n_blocks_sent = 0;
    n_blocks_checked = 0;
    n_cfg_writes = 0;
    hold_left = 0;
    stall_left = 0;
    quiet_cycles = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    // predictor reset state: zero key, 8 rounds
    key_hi_q = '0;
    key_lo_q = '0;
    rounds_q = ROUND_COUNT_RESET;
    rebuild_subkeys();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random();
    test_backpressure();
    test_pause();
    test_no_idle();
    sender_idle();
    wait_drained();
    repeat (400) @(posedge clk);

    $display("covered %0d blocks (encrypt and decrypt), %0d results checked, %0d reg writes",
             n_blocks_sent, n_blocks_checked, n_cfg_writes);
    $display("rounds 0, 1, 9, 36 and saturated, extreme keys and blocks, stalls and pauses");
    if (n_errors == 0 && pending_blocks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/misty1_pkg.sv
src/misty1_block_cipher_top.sv
sim/tb.sv
